### sv/tfr_pkg.sv
// ============================================================================
// tfr_pkg: telemetry frame receiver shared definitions
// Widths, frame layout constants, reset values, register indexes and command codes.
// ============================================================================
`default_nettype none

package tfr_pkg;

    // Frame layout
    localparam int          MAX_FRAME_BYTES_DEF = 32;
    localparam int          MIN_FRAME_BYTES     = 22;
    localparam int          FUNC_POS            = 2;
    localparam int          VOLT_HI_POS         = 20;
    localparam int          VOLT_LO_POS         = 21;
    localparam logic [7:0]  HEADER_MARK         = 8'hAA;

    // Configuration register reset values
    localparam logic [15:0] LOSS_LIMIT_RESET    = 16'd1000;
    localparam logic [7:0]  FUNC_CODE_RESET     = 8'h03;

    // Field widths
    localparam int          DATA_W              = 8;
    localparam int          VOLT_W              = 16;
    localparam int          LOSS_W              = 16;
    localparam int          CFG_INDEX_W         = 1;
    localparam int          CFG_DATA_W          = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOSS_LIMIT = 1'b0,
        REG_FUNC_CODE  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_POLL = 1'b1
    } command_t;

endpackage : tfr_pkg

`default_nettype wire

### sv/tfr_if.sv
// ============================================================================
// tfr_if: telemetry frame receiver channel interfaces
// Valid/ready channels for input words and result words.
// ============================================================================
`default_nettype none

interface tfr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [tfr_pkg::DATA_W-1:0]  data_byte;
    logic                        end_of_frame;

    modport source (output valid, output command, output data_byte,
                    output end_of_frame, input ready);
    modport sink   (input valid, input command, input data_byte,
                    input end_of_frame, output ready);
endinterface : tfr_in_if

interface tfr_out_if;
    logic                        valid;
    logic                        ready;
    logic [tfr_pkg::VOLT_W-1:0]  voltage;
    logic                        frame_accepted;
    logic                        frame_rejected;
    logic                        link_lost;

    modport source (output valid, output voltage, output frame_accepted,
                    output frame_rejected, output link_lost, input ready);
    modport sink   (input valid, input voltage, input frame_accepted,
                    input frame_rejected, input link_lost, output ready);
endinterface : tfr_out_if

`default_nettype wire

### sv/telemetry_frame_receiver_unit.sv
// ============================================================================
// telemetry_frame_receiver_unit: additive checksum frame receiver
// Checks framed telemetry bytes (header, function code, 8-bit sum) and
// captures the big-endian voltage field; counts idle polls for link loss.
// ============================================================================
//
//  Channel   Dir   Handshake        Word contents
//  --------  ----  ---------------  ------------------------------------------
//  in_ch     in    valid/ready      command, data_byte, end_of_frame
//  out_ch    out   valid/ready      voltage, frame_accepted, frame_rejected,
//                                   link_lost
//  cfg       in    cfg_wr_en only   cfg_index, cfg_data (loss limit, func code)
//
//  One input word per cycle, one result word per input word, visible the
//  cycle after acceptance. The only stage is the result register; in_ch is
//  ready whenever that register is empty or being drained in the same cycle.
//  A stall on out_ch backs up into in_ch with no loss.
//  rst_n (async, active low) clears frame state, counters, voltage and
//  restores loss_limit = 1000, voltage_function_code = 3.
//
`default_nettype none

module telemetry_frame_receiver_unit #(
    parameter int MAX_FRAME_BYTES = tfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tfr_in_if.sink                               in_ch,
    tfr_out_if.source                            out_ch,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Position saturates at MAX_FRAME_BYTES, so it needs room for that value.
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_HDR   = POS_W'(tfr_pkg::FUNC_POS);
    localparam logic [POS_W-1:0] POS_FUNC  = POS_W'(tfr_pkg::FUNC_POS);
    localparam logic [POS_W-1:0] POS_VHI   = POS_W'(tfr_pkg::VOLT_HI_POS);
    localparam logic [POS_W-1:0] POS_VLO   = POS_W'(tfr_pkg::VOLT_LO_POS);
    // Checksum at this position or later means length >= minimum
    localparam logic [POS_W-1:0] POS_SHORT = POS_W'(tfr_pkg::MIN_FRAME_BYTES - 1);

    // Configuration registers
    logic [tfr_pkg::LOSS_W-1:0] loss_limit_reg;
    logic [tfr_pkg::DATA_W-1:0] func_code_reg;

    // Frame state
    logic [POS_W-1:0]           pos_reg,       pos_next;
    logic [tfr_pkg::DATA_W-1:0] sum_reg,       sum_next;
    logic                       hdr_good_reg,  hdr_good_next;
    logic                       func_match_reg, func_match_next;
    logic [tfr_pkg::DATA_W-1:0] volt_hi_reg,   volt_hi_next;
    logic [tfr_pkg::DATA_W-1:0] volt_lo_reg,   volt_lo_next;
    logic [tfr_pkg::LOSS_W-1:0] idle_cnt_reg,  idle_cnt_next;
    logic [tfr_pkg::VOLT_W-1:0] volt_reg,      volt_next;

    // Result register
    logic                       out_valid_reg;
    logic [tfr_pkg::VOLT_W-1:0] out_volt_reg;
    logic                       out_acc_reg,   acc_next;
    logic                       out_rej_reg,   rej_next;
    logic                       out_lost_reg,  lost_next;

    logic                       in_fire;
    logic [tfr_pkg::LOSS_W:0]   idle_inc;

    // Result slot is free when empty or drained this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.voltage        = out_volt_reg;
    assign out_ch.frame_accepted = out_acc_reg;
    assign out_ch.frame_rejected = out_rej_reg;
    assign out_ch.link_lost      = out_lost_reg;

    // 17-bit compare so a limit of 65535 still trips
    assign idle_inc = {1'b0, idle_cnt_reg} + (tfr_pkg::LOSS_W + 1)'(1);

    // ---------------------------------------------------------------------
    // Next-state and result logic for one accepted word
    // ---------------------------------------------------------------------
    always_comb
    begin
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        hdr_good_next   = hdr_good_reg;
        func_match_next = func_match_reg;
        volt_hi_next    = volt_hi_reg;
        volt_lo_next    = volt_lo_reg;
        idle_cnt_next   = idle_cnt_reg;
        volt_next       = volt_reg;
        acc_next        = 1'b0;
        rej_next        = 1'b0;
        lost_next       = 1'b0;

        if (in_ch.command == tfr_pkg::CMD_POLL)
        begin
            if (idle_inc > {1'b0, loss_limit_reg})
            begin
                idle_cnt_next = '0;
                volt_next     = '0;
                lost_next     = 1'b1;
            end
            else
            begin
                idle_cnt_next = idle_inc[tfr_pkg::LOSS_W-1:0];
            end
        end
        else
        begin
            idle_cnt_next = '0;
            if (!in_ch.end_of_frame)
            begin
                // Bytes past the maximum are dropped; position saturates
                if (pos_reg < POS_MAX)
                begin
                    sum_next = sum_reg + in_ch.data_byte;
                    if (pos_reg < POS_HDR && in_ch.data_byte != tfr_pkg::HEADER_MARK)
                        hdr_good_next = 1'b0;
                    if (pos_reg == POS_FUNC)
                        func_match_next = (in_ch.data_byte == func_code_reg);
                    if (pos_reg == POS_VHI)
                        volt_hi_next = in_ch.data_byte;
                    if (pos_reg == POS_VLO)
                        volt_lo_next = in_ch.data_byte;
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else
            begin
                // Checksum byte: oversized, short, then sum/header check
                if (pos_reg >= POS_MAX)
                    rej_next = 1'b1;
                else if (pos_reg < POS_SHORT)
                    rej_next = 1'b1;
                else if (sum_reg == in_ch.data_byte && hdr_good_reg)
                begin
                    acc_next = 1'b1;
                    if (func_match_reg)
                        volt_next = {volt_hi_reg, volt_lo_reg};
                end
                else
                    rej_next = 1'b1;

                pos_next        = '0;
                sum_next        = '0;
                hdr_good_next   = 1'b1;
                func_match_next = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_limit_reg <= tfr_pkg::LOSS_LIMIT_RESET;
            func_code_reg  <= tfr_pkg::FUNC_CODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (tfr_pkg::cfg_index_t'(cfg_index))
                tfr_pkg::REG_LOSS_LIMIT: loss_limit_reg <= cfg_data[tfr_pkg::LOSS_W-1:0];
                tfr_pkg::REG_FUNC_CODE:  func_code_reg  <= cfg_data[tfr_pkg::DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Frame and link state
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            sum_reg        <= '0;
            hdr_good_reg   <= 1'b1;
            func_match_reg <= 1'b0;
            volt_hi_reg    <= '0;
            volt_lo_reg    <= '0;
            idle_cnt_reg   <= '0;
            volt_reg       <= '0;
        end
        else if (in_fire)
        begin
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            hdr_good_reg   <= hdr_good_next;
            func_match_reg <= func_match_next;
            volt_hi_reg    <= volt_hi_next;
            volt_lo_reg    <= volt_lo_next;
            idle_cnt_reg   <= idle_cnt_next;
            volt_reg       <= volt_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_volt_reg <= volt_next;
            out_acc_reg  <= acc_next;
            out_rej_reg  <= rej_next;
            out_lost_reg <= lost_next;
        end
    end

endmodule : telemetry_frame_receiver_unit

`default_nettype wire

### sv/tfr_checker.sv
// ============================================================================
// tfr_checker: port-level checks for the telemetry frame receiver
// Watches the result channel and flags consistency and handshake slips.
// ============================================================================
`default_nettype none

module tfr_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [tfr_pkg::VOLT_W-1:0]  voltage,
    input wire logic                        frame_accepted,
    input wire logic                        frame_rejected,
    input wire logic                        link_lost
);

    // At most one event flag per result word
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({frame_accepted, frame_rejected, link_lost}))
        else $error("more than one event flag in a result word");

    // Link loss clears the reported voltage
    a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && link_lost) |-> (voltage == '0))
        else $error("voltage not cleared on link loss");

    // Stalled word stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped while stalled");

    // Stalled word keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(voltage) && $stable(frame_accepted)
            && $stable(frame_rejected) && $stable(link_lost)))
        else $error("result word changed while stalled");

endmodule : tfr_checker

bind telemetry_frame_receiver_unit tfr_checker u_tfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .voltage        (out_ch.voltage),
    .frame_accepted (out_ch.frame_accepted),
    .frame_rejected (out_ch.frame_rejected),
    .link_lost      (out_ch.link_lost)
);

`default_nettype wire
